/* rtl/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// sfla_pkg: shared definitions for the size-class allocator
// Heap geometry, size-class layout, field widths, codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfla_pkg;

    // Heap and class geometry
    localparam int HEAP_LOG2         = 20;
    localparam int QUANTUM_LOG2      = 4;
    localparam int LINEAR_LIMIT_LOG2 = 9;
    localparam int MAX_BLOCK_LOG2    = 25;

    localparam int LINEAR_CLASSES = (1 << (LINEAR_LIMIT_LOG2 - QUANTUM_LOG2)) - 1;
    localparam int NUM_CLASSES    = LINEAR_CLASSES + (MAX_BLOCK_LOG2 - LINEAR_LIMIT_LOG2);
    localparam int CLS_W          = $clog2(NUM_CLASSES);
    localparam int LINK_AW        = HEAP_LOG2 - QUANTUM_LOG2;
    localparam int LINK_DEPTH     = 1 << LINK_AW;
    localparam int HEAD_W         = LINK_AW + 1;

    // Field widths
    localparam int SIZE_W  = 32;
    localparam int ADDR_W  = 20;
    localparam int GSIZE_W = 25;
    localparam int SLOT_W  = 21;
    localparam int BYTES_W = 21;
    localparam int OBJS_W  = 17;
    localparam int BUMP_W  = HEAP_LOG2 + 1;
    localparam int SUM_W   = GSIZE_W + 1;

    localparam int MIN_SIZE    = 16;
    localparam int SLOT_SHIFT  = 3;
    localparam int LARGE_SLOTS = 4096;

    // Request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SMALL = 2'd1;
    localparam logic [1:0] ST_BIG   = 2'd2;
    localparam logic [1:0] ST_OOM   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // capture accepted request
        logic classify;    // classify size, read class head
        logic eval;        // decide pop / bump / free, commit non-pop cases
        logic pop_commit;  // finish a list pop with the link word
        logic load_out;    // move result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop;         // current alloc pops a non-empty class list
    } stat_t;

endpackage

/* rtl/sfla_ctrl.sv */
// ----------------------------------------------------------------------------
// sfla_ctrl: request sequencer
// Steps each request through classify, head lookup, optional link read and
// result hand-off. Owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module sfla_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  sfla_pkg::stat_t stat,
    output sfla_pkg::cmd_t  cmd
);
    import sfla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_HEAD,
        S_LINK,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Command decode
    always_comb
    begin
        cmd            = '0;
        cmd.load_in    = (state_reg == S_IDLE) && in_valid;
        cmd.classify   = (state_reg == S_CLASS);
        cmd.eval       = (state_reg == S_HEAD);
        cmd.pop_commit = (state_reg == S_LINK);
        cmd.load_out   = (state_reg == S_DONE) && out_free;
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result loads as the old one leaves, else valid drops
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_CLASS;
                end
                S_CLASS:
                begin
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    state_reg <= stat.pop ? S_LINK : S_DONE;
                end
                S_LINK:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/sfla_dp.sv */
// ----------------------------------------------------------------------------
// sfla_dp: allocator datapath
// Size classifier, class head memory with valid bits, link memory, bump
// pointer, usage counters and the result register.
// ----------------------------------------------------------------------------
module sfla_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sfla_pkg::cmd_t                 cmd,
    output sfla_pkg::stat_t                stat,
    input  logic                           req_type,
    input  logic [sfla_pkg::SIZE_W-1:0]    request_size,
    input  logic [sfla_pkg::ADDR_W-1:0]    block_address,
    output logic [1:0]                     status,
    output logic [sfla_pkg::ADDR_W-1:0]    granted_address,
    output logic [sfla_pkg::GSIZE_W-1:0]   granted_size,
    output logic [sfla_pkg::SLOT_W-1:0]    slot_count,
    output logic                           large_object,
    output logic [sfla_pkg::BYTES_W-1:0]   bytes_in_use,
    output logic [sfla_pkg::OBJS_W-1:0]    objects_in_use
);
    import sfla_pkg::*;

    localparam logic [SIZE_W-1:0]  LIN_LIMIT = SIZE_W'(LINEAR_CLASSES) << QUANTUM_LOG2;
    localparam logic [SUM_W-1:0]   HEAP_BYTES = SUM_W'(1) << HEAP_LOG2;
    localparam logic [SUM_W-1:0]   BYTE_MAX = SUM_W'((1 << BYTES_W) - 1);
    localparam logic [OBJS_W-1:0]  OBJ_MAX = '1;

    // Leading-one position by halving, five narrow steps
    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [31:0] x;
        logic [4:0]  p;
        x = v;
        p = '0;
        if (x[31:16] != 16'd0)
        begin
            p[4] = 1'b1;
            x    = x >> 16;
        end
        if (x[15:8] != 8'd0)
        begin
            p[3] = 1'b1;
            x    = x >> 8;
        end
        if (x[7:4] != 4'd0)
        begin
            p[2] = 1'b1;
            x    = x >> 4;
        end
        if (x[3:2] != 2'd0)
        begin
            p[1] = 1'b1;
            x    = x >> 2;
        end
        if (x[1])
            p[0] = 1'b1;
        return p;
    endfunction

    // Request registers
    logic                  req_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ADDR_W-1:0]     addr_reg;

    // Per-request working registers
    logic [1:0]            st_reg;
    logic [CLS_W-1:0]      cls_reg;
    logic [GSIZE_W-1:0]    gsize_reg;
    logic [ADDR_W-1:0]     gaddr_reg;
    logic [HEAD_W-1:0]     head_rd_reg;
    logic                  head_vld_reg;
    logic [HEAD_W-1:0]     link_rd_reg;

    // Memories and their valid bits
    logic [HEAD_W-1:0]     head_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] head_valid_reg;
    logic [HEAD_W-1:0]     link_mem [LINK_DEPTH];

    // Allocator state
    logic [BUMP_W-1:0]     bump_reg;
    logic [BYTES_W-1:0]    bytes_reg;
    logic [OBJS_W-1:0]     objs_reg;

    // Result register
    logic [1:0]            status_reg;
    logic [ADDR_W-1:0]     gaddr_out_reg;
    logic [GSIZE_W-1:0]    gsize_out_reg;
    logic [SLOT_W-1:0]     slots_out_reg;
    logic                  large_out_reg;
    logic [BYTES_W-1:0]    bytes_out_reg;
    logic [OBJS_W-1:0]     objs_out_reg;

    // Classifier
    logic [SIZE_W-1:0]     size_m1;
    logic [4:0]            top_bit;
    logic                  is_small;
    logic                  is_linear;
    logic                  is_big;
    logic [CLS_W-1:0]      cls_lin;
    logic [1:0]            st_c;
    logic [CLS_W-1:0]      cls_c;
    logic [GSIZE_W-1:0]    gsize_c;

    always_comb
    begin
        size_m1   = size_reg - SIZE_W'(1);
        top_bit   = msb_pos(size_m1);
        is_small  = size_reg < SIZE_W'(MIN_SIZE);
        is_linear = size_m1 < LIN_LIMIT;
        is_big    = size_m1[SIZE_W-1:MAX_BLOCK_LOG2-1] != '0;
        cls_lin   = size_m1[QUANTUM_LOG2 +: CLS_W];
        if (is_small)
        begin
            st_c    = ST_SMALL;
            cls_c   = '0;
            gsize_c = '0;
        end
        else if (is_linear)
        begin
            st_c    = ST_OK;
            cls_c   = cls_lin;
            gsize_c = GSIZE_W'(cls_lin + CLS_W'(1)) << QUANTUM_LOG2;
        end
        else if (is_big)
        begin
            st_c    = ST_BIG;
            cls_c   = '0;
            gsize_c = '0;
        end
        else
        begin
            // top_bit + 1 is the power-of-two exponent
            st_c    = ST_OK;
            cls_c   = CLS_W'(top_bit) + CLS_W'(LINEAR_CLASSES + 1 - LINEAR_LIMIT_LOG2);
            gsize_c = GSIZE_W'(1) << (top_bit + 5'd1);
        end
    end

    // Decision in the head stage
    logic                  ok;
    logic                  is_free;
    logic [HEAD_W-1:0]     head_cur;
    logic [HEAD_W-1:0]     head_m1;
    logic [LINK_AW-1:0]    pop_idx;
    logic [LINK_AW-1:0]    free_idx;
    logic [SUM_W-1:0]      bump_sum;
    logic                  fits;
    logic                  pop;
    logic                  bump_alloc;
    logic                  do_free;
    logic                  do_inc;
    logic                  head_we;
    logic [HEAD_W-1:0]     head_wd;
    logic [SUM_W-1:0]      bytes_sum;
    logic [BYTES_W-1:0]    bytes_inc;
    logic [BYTES_W-1:0]    bytes_dec;

    always_comb
    begin
        ok         = (st_reg == ST_OK);
        is_free    = (req_reg == REQ_FREE);
        head_cur   = head_vld_reg ? head_rd_reg : '0;
        head_m1    = head_cur - HEAD_W'(1);
        pop_idx    = head_m1[LINK_AW-1:0];
        free_idx   = addr_reg[QUANTUM_LOG2 +: LINK_AW];
        bump_sum   = SUM_W'(bump_reg) + SUM_W'(gsize_reg);
        fits       = bump_sum <= HEAP_BYTES;
        pop        = ok && !is_free && (head_cur != '0);
        bump_alloc = cmd.eval && ok && !is_free && !pop && fits;
        do_free    = cmd.eval && ok && is_free;
        do_inc     = bump_alloc || cmd.pop_commit;
        head_we    = do_free || cmd.pop_commit;
        head_wd    = is_free ? (HEAD_W'(free_idx) + HEAD_W'(1)) : link_rd_reg;
        bytes_sum  = SUM_W'(bytes_reg) + SUM_W'(gsize_reg);
        bytes_inc  = (bytes_sum > BYTE_MAX) ? BYTE_MAX[BYTES_W-1:0]
                                            : bytes_sum[BYTES_W-1:0];
        bytes_dec  = (GSIZE_W'(bytes_reg) > gsize_reg)
                     ? (bytes_reg - gsize_reg[BYTES_W-1:0]) : '0;
        stat.pop   = pop;
    end

    // Request capture and per-request registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg  <= req_type;
            size_reg <= request_size;
            addr_reg <= block_address;
        end
        if (cmd.classify)
        begin
            st_reg    <= st_c;
            cls_reg   <= cls_c;
            gsize_reg <= gsize_c;
            gaddr_reg <= '0;
        end
        if (cmd.eval && ok && !is_free && !pop)
        begin
            if (fits)
                gaddr_reg <= bump_reg[ADDR_W-1:0];
            else
                st_reg <= ST_OOM;
        end
        if (cmd.pop_commit)
            gaddr_reg <= ADDR_W'(pop_idx) << QUANTUM_LOG2;
    end

    // Class head memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.classify)
            head_rd_reg <= head_mem[cls_c];
        if (head_we)
            head_mem[cls_reg] <= head_wd;
    end

    // Head valid bits: a class never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            head_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.classify)
                head_vld_reg <= head_valid_reg[cls_c];
            if (head_we)
                head_valid_reg[cls_reg] <= 1'b1;
        end
    end

    // Link memory: push writes the old head, pop reads the next link
    always_ff @(posedge clk)
    begin
        if (cmd.eval && pop)
            link_rd_reg <= link_mem[pop_idx];
        if (do_free)
            link_mem[free_idx] <= head_cur;
    end

    // Bump pointer and usage counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg  <= '0;
            bytes_reg <= '0;
            objs_reg  <= '0;
        end
        else
        begin
            if (bump_alloc)
                bump_reg <= bump_sum[BUMP_W-1:0];
            if (do_inc)
            begin
                bytes_reg <= bytes_inc;
                if (objs_reg != OBJ_MAX)
                    objs_reg <= objs_reg + OBJS_W'(1);
            end
            else if (do_free)
            begin
                bytes_reg <= bytes_dec;
                if (objs_reg != '0)
                    objs_reg <= objs_reg - OBJS_W'(1);
            end
        end
    end

    // Result fields
    logic [GSIZE_W-1:0]    gsize_res;
    logic [GSIZE_W-1:0]    gsize_m1;
    logic [SLOT_W-1:0]     slots_res;

    always_comb
    begin
        gsize_res = ok ? gsize_reg : '0;
        gsize_m1  = gsize_res - GSIZE_W'(1);
        slots_res = (gsize_res != '0) ? SLOT_W'(gsize_m1 >> SLOT_SHIFT) : '0;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg    <= st_reg;
            gaddr_out_reg <= ok ? gaddr_reg : '0;
            gsize_out_reg <= gsize_res;
            slots_out_reg <= slots_res;
            large_out_reg <= slots_res >= SLOT_W'(LARGE_SLOTS);
            bytes_out_reg <= bytes_reg;
            objs_out_reg  <= objs_reg;
        end
    end

    assign status          = status_reg;
    assign granted_address = gaddr_out_reg;
    assign granted_size    = gsize_out_reg;
    assign slot_count      = slots_out_reg;
    assign large_object    = large_out_reg;
    assign bytes_in_use    = bytes_out_reg;
    assign objects_in_use  = objs_out_reg;

endmodule

/* rtl/segregated_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// segregated_free_list_allocator: size-class heap allocator
// Rounds each alloc or free request to a size class, pops or pushes the
// class free list, or bump-allocates from the heap.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_ready) carries req_type, request_size and
//   block_address. Result channel (out_valid / out_ready) returns exactly one
//   result per request, in order.
//   One request is worked at a time. After acceptance it passes the classify,
//   head and done states, and the result register loads as it leaves done;
//   an allocate that pops a free list passes the link state as well, for the
//   synchronous read of the link memory. A new request can be accepted the
//   cycle after the result loads, and not before the last one is finished.
//   The result register parts the two sides: the next request is accepted
//   and worked while an earlier result waits. If the receiver stalls, the
//   finished request holds until the result register frees up.
//   Reset empties all class lists (valid bits, no sweep), zeroes the bump
//   pointer and the usage counters; the link memory is not cleared.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [sfla_pkg::SIZE_W-1:0]    request_size,
    input  logic [sfla_pkg::ADDR_W-1:0]    block_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [sfla_pkg::ADDR_W-1:0]    granted_address,
    output logic [sfla_pkg::GSIZE_W-1:0]   granted_size,
    output logic [sfla_pkg::SLOT_W-1:0]    slot_count,
    output logic                           large_object,
    output logic [sfla_pkg::BYTES_W-1:0]   bytes_in_use,
    output logic [sfla_pkg::OBJS_W-1:0]    objects_in_use
);
    import sfla_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    sfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    sfla_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req_type),
        .request_size    (request_size),
        .block_address   (block_address),
        .status          (status),
        .granted_address (granted_address),
        .granted_size    (granted_size),
        .slot_count      (slot_count),
        .large_object    (large_object),
        .bytes_in_use    (bytes_in_use),
        .objects_in_use  (objects_in_use)
    );

endmodule

/* tb/sv/segregated_free_list_allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_checker: result predictor and comparator
// Watches the request and result channels of the allocator. Every accepted
// request is run through a local model of the class lists, bump pointer and
// usage counters. The grant it predicts is queued, and each returned result
// is compared field by field against the oldest queued grant.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           req_type,
    input  logic [sfla_pkg::SIZE_W-1:0]    request_size,
    input  logic [sfla_pkg::ADDR_W-1:0]    block_address,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [1:0]                     status,
    input  logic [sfla_pkg::ADDR_W-1:0]    granted_address,
    input  logic [sfla_pkg::GSIZE_W-1:0]   granted_size,
    input  logic [sfla_pkg::SLOT_W-1:0]    slot_count,
    input  logic                           large_object,
    input  logic [sfla_pkg::BYTES_W-1:0]   bytes_in_use,
    input  logic [sfla_pkg::OBJS_W-1:0]    objects_in_use,
    output int                             fail_count,
    output int                             outstanding,
    output int                             result_count,
    output int                             ok_count,
    output int                             small_count,
    output int                             big_count,
    output int                             oom_count,
    output int                             reuse_count
);
    import sfla_pkg::*;

    localparam longint unsigned HEAP_BYTES = 64'd1 << HEAP_LOG2;

    typedef struct {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  addr;
        logic [GSIZE_W-1:0] size;
        logic [SLOT_W-1:0]  slots;
        logic               large_obj;
        logic [BYTES_W-1:0] bytes;
        logic [OBJS_W-1:0]  objects;
    } grant_t;

    // Allocator state as seen by the model; heads and links hold index + 1
    logic [HEAD_W-1:0]  free_head [NUM_CLASSES];
    logic [HEAD_W-1:0]  free_link [LINK_DEPTH];
    logic [BUMP_W-1:0]  heap_top;
    logic [BYTES_W-1:0] live_bytes;
    logic [OBJS_W-1:0]  live_objects;

    grant_t pending_grants [$];
    grant_t want;

    // Round a size to its class; returns the status of the rounding
    function automatic logic [1:0] size_class(input logic [SIZE_W-1:0] sz,
                                              output int cls,
                                              output logic [GSIZE_W-1:0] gsz);
        longint unsigned wide;
        longint unsigned lin;
        longint unsigned rounded;
        int lg;
        cls = 0;
        gsz = '0;
        wide = sz;
        lg = LINEAR_LIMIT_LOG2;
        if (wide < MIN_SIZE)
            return ST_SMALL;
        lin = (wide - 1) >> QUANTUM_LOG2;
        if (lin < LINEAR_CLASSES)
        begin
            cls = int'(lin);
            rounded = (lin + 1) << QUANTUM_LOG2;
            gsz = rounded[GSIZE_W-1:0];
            return ST_OK;
        end
        while (lg < 63 && wide > (64'd1 << lg))
            lg++;
        if (lg >= MAX_BLOCK_LOG2)
            return ST_BIG;
        cls = LINEAR_CLASSES + lg - LINEAR_LIMIT_LOG2;
        rounded = 64'd1 << lg;
        gsz = rounded[GSIZE_W-1:0];
        return ST_OK;
    endfunction

    // Apply one request to the model state and return the grant it gives
    function automatic grant_t apply_request(input logic kind,
                                             input logic [SIZE_W-1:0] sz,
                                             input logic [ADDR_W-1:0] ba);
        grant_t g;
        int cls;
        logic [GSIZE_W-1:0] gsz;
        logic [GSIZE_W-1:0] span;
        logic [1:0] st;
        logic [HEAD_W-1:0] head;
        logic [LINK_AW-1:0] idx;
        logic [ADDR_W-1:0] gaddr;
        longint unsigned sum;
        st = size_class(sz, cls, gsz);
        gaddr = '0;
        if (st == ST_OK)
        begin
            if (kind == REQ_ALLOC)
            begin
                head = free_head[cls];
                sum = heap_top;
                sum += gsz;
                if (head != '0)
                begin
                    // reuse the most recently freed block of this class
                    idx = head[LINK_AW-1:0] - 1'b1;
                    gaddr = {idx, {QUANTUM_LOG2{1'b0}}};
                    free_head[cls] = free_link[idx];
                    reuse_count++;
                end
                else if (sum <= HEAP_BYTES)
                begin
                    gaddr = heap_top[ADDR_W-1:0];
                    heap_top = sum[BUMP_W-1:0];
                end
                else
                begin
                    st = ST_OOM;
                end
                if (st == ST_OK)
                begin
                    sum = live_bytes;
                    sum += gsz;
                    live_bytes = (sum > longint'({BYTES_W{1'b1}})) ? '1 : sum[BYTES_W-1:0];
                    if (live_objects != '1)
                        live_objects++;
                end
            end
            else
            begin
                // push onto the class list; low quantum bits are dropped
                idx = ba[ADDR_W-1:QUANTUM_LOG2];
                free_link[idx] = free_head[cls];
                free_head[cls] = {1'b0, idx} + 1'b1;
                live_bytes = (live_bytes > gsz) ? live_bytes - gsz[BYTES_W-1:0] : '0;
                if (live_objects != '0)
                    live_objects--;
            end
        end
        if (st != ST_OK)
        begin
            gsz = '0;
            gaddr = '0;
        end
        span = (gsz == '0) ? '0 : (gsz - 1'b1) >> SLOT_SHIFT;
        g.status = st;
        g.addr = gaddr;
        g.size = gsz;
        g.slots = span[SLOT_W-1:0];
        g.large_obj = (span >= LARGE_SLOTS);
        g.bytes = live_bytes;
        g.objects = live_objects;
        return g;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want_v,
                                        input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
                free_head[c] = '0;
            heap_top = '0;
            live_bytes = '0;
            live_objects = '0;
            pending_grants.delete();
            fail_count = 0;
            outstanding = 0;
            result_count = 0;
            ok_count = 0;
            small_count = 0;
            big_count = 0;
            oom_count = 0;
            reuse_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_grants.push_back(apply_request(req_type, request_size, block_address));
            if (out_valid && out_ready)
            begin
                result_count++;
                if (pending_grants.size() == 0)
                begin
                    $error("result returned with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    case (want.status)
                        ST_OK:    ok_count++;
                        ST_SMALL: small_count++;
                        ST_BIG:   big_count++;
                        default:  oom_count++;
                    endcase
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("granted_address", 64'(want.addr), 64'(granted_address));
                    check_field("granted_size", 64'(want.size), 64'(granted_size));
                    check_field("slot_count", 64'(want.slots), 64'(slot_count));
                    check_field("large_object", 64'(want.large_obj), 64'(large_object));
                    check_field("bytes_in_use", 64'(want.bytes), 64'(bytes_in_use));
                    check_field("objects_in_use", 64'(want.objects), 64'(objects_in_use));
                end
            end
            outstanding = pending_grants.size();
        end
    end

endmodule

/* tb/sv/segregated_free_list_allocator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_test: top-level test of the allocator
// Sends a directed set of alloc and free requests covering size limits, class
// boundaries, heap exhaustion and list reuse, then a long random mix of
// matched alloc/free pairs with noise, under random idling on both sides.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_test;
    import sfla_pkg::*;

    localparam int RANDOM_ITEMS   = 1726;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } block_t;

    typedef struct {
        logic              kind;
        logic [SIZE_W-1:0] size;
    } issued_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                req_type = REQ_ALLOC;
    logic [SIZE_W-1:0]   request_size = '0;
    logic [ADDR_W-1:0]   block_address = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   granted_address;
    logic [GSIZE_W-1:0]  granted_size;
    logic [SLOT_W-1:0]   slot_count;
    logic                large_object;
    logic [BYTES_W-1:0]  bytes_in_use;
    logic [OBJS_W-1:0]   objects_in_use;

    int fail_count;
    int outstanding;
    int result_count;
    int ok_count;
    int small_count;
    int big_count;
    int oom_count;
    int reuse_count;

    // Stimulus bookkeeping: requests in flight, live and recently freed blocks
    issued_t issued [$];
    block_t  live_blocks [$];
    block_t  freed_blocks [$];
    bit      sender_steady = 1'b0;
    bit      receiver_steady = 1'b0;
    int      long_holds = 0;
    int      idle_cycles = 0;

    segregated_free_list_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .request_size    (request_size),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_address (granted_address),
        .granted_size    (granted_size),
        .slot_count      (slot_count),
        .large_object    (large_object),
        .bytes_in_use    (bytes_in_use),
        .objects_in_use  (objects_in_use)
    );

    segregated_free_list_allocator_checker grant_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .request_size    (request_size),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_address (granted_address),
        .granted_size    (granted_size),
        .slot_count      (slot_count),
        .large_object    (large_object),
        .bytes_in_use    (bytes_in_use),
        .objects_in_use  (objects_in_use),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .result_count    (result_count),
        .ok_count        (ok_count),
        .small_count     (small_count),
        .big_count       (big_count),
        .oom_count       (oom_count),
        .reuse_count     (reuse_count)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: consecutive cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("** segregated_free_list_allocator: FAILED **");
            $finish;
        end
    end

    // Offer one request after a random gap; returns at the accepting edge
    task automatic drive_request(input logic kind, input logic [SIZE_W-1:0] sz,
                                 input logic [ADDR_W-1:0] ba);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type <= kind;
        request_size <= sz;
        block_address <= ba;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        issued.push_back('{kind, sz});
    endtask

    // Result side: random stalls, two long hold-offs, harvest granted blocks
    initial
    begin
        int stall;
        int taken;
        issued_t req;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken % 50 == 0)
                receiver_steady = ($urandom_range(0, 3) == 0);
            if (taken == 300 || taken == 1100) begin
                stall = LONG_HOLD;
                long_holds++;
            end else begin
                stall = receiver_steady ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (issued.size() != 0) begin
                req = issued.pop_front();
                if (req.kind == REQ_ALLOC && status == ST_OK)
                    live_blocks.push_back('{granted_address, req.size});
            end
        end
    end

    // Request side and verdict
    initial
    begin
        int n;
        int pick;
        int r;
        int slot;
        logic [SIZE_W-1:0] sz;
        block_t blk;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: size limits, class edges, exhaustion, list reuse
        drive_request(REQ_FREE,  32'd64, 20'h00040);         // free into empty counters
        drive_request(REQ_ALLOC, 32'd0, '0);                  // zero size
        drive_request(REQ_ALLOC, 32'd15, '0);                 // just under minimum
        drive_request(REQ_FREE,  32'd15, '0);                 // undersize free
        drive_request(REQ_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF);   // all ones
        drive_request(REQ_ALLOC, 32'h0100_0001, '0);          // just over largest class
        drive_request(REQ_FREE,  32'h0100_0001, '0);          // oversize free
        drive_request(REQ_ALLOC, 32'h0100_0000, '0);          // largest class, heap too small
        drive_request(REQ_ALLOC, 32'd16, '0);                 // smallest class
        drive_request(REQ_ALLOC, 32'd496, '0);                // last linear class
        drive_request(REQ_ALLOC, 32'd497, '0);                // first power-of-two class
        drive_request(REQ_ALLOC, 32'd513, '0);
        drive_request(REQ_ALLOC, 32'd32768, '0);              // just below large object
        drive_request(REQ_ALLOC, 32'd32769, '0);              // large object
        drive_request(REQ_ALLOC, 32'd524288, '0);
        drive_request(REQ_ALLOC, 32'd524288, '0);             // bump pointer runs out
        drive_request(REQ_FREE,  32'd16, 20'h00000);
        drive_request(REQ_ALLOC, 32'd16, '0);                 // pops the block just freed
        drive_request(REQ_FREE,  32'd497, 20'h0020F);         // low address bits ignored
        drive_request(REQ_ALLOC, 32'd500, '0);
        drive_request(REQ_ALLOC, 32'd64, '0);                 // pops the stray first free
        drive_request(REQ_FREE,  32'd524288, 20'd100352);     // large free
        drive_request(REQ_FREE,  32'd16, 20'hFFFFF);          // top of heap address
        drive_request(REQ_ALLOC, 32'd16, '0);

        // Random: mostly matched alloc/free traffic, some noise
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 150)
                pick = 60;
            if (pick < 45 || (pick < 80 && live_blocks.size() == 0)) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    sz = $urandom_range(16, 496);
                else if (r < 85)
                    sz = $urandom_range(497, 8192);
                else if (r < 97)
                    sz = $urandom_range(8193, 131072);
                else
                    sz = $urandom_range(131073, 1 << HEAP_LOG2);
                drive_request(REQ_ALLOC, sz, ADDR_W'($urandom()));
            end else if (pick < 80) begin
                slot = $urandom_range(0, live_blocks.size() - 1);
                blk = live_blocks[slot];
                live_blocks.delete(slot);
                freed_blocks.push_back(blk);
                if (freed_blocks.size() > 8)
                    void'(freed_blocks.pop_front());
                drive_request(REQ_FREE, blk.size,
                              blk.addr | ADDR_W'($urandom_range(0, 15)));
            end else begin
                case ($urandom_range(0, 4))
                    0: drive_request(1'($urandom()), $urandom(), ADDR_W'($urandom()));
                    1: drive_request(1'($urandom()), $urandom_range(0, 15),
                                     ADDR_W'($urandom()));
                    2: begin
                        // double free of a recently released block
                        if (freed_blocks.size() != 0) begin
                            blk = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
                            drive_request(REQ_FREE, blk.size, blk.addr);
                        end else begin
                            drive_request(REQ_ALLOC, 32'd16, '0);
                        end
                    end
                    3: drive_request(REQ_ALLOC, $urandom_range(32'h0100_0000, 32'h0100_1000),
                                     ADDR_W'($urandom()));
                    default: drive_request(REQ_FREE, $urandom_range(16, 4096),
                                           ADDR_W'($urandom()));
                endcase
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d results: %0d ok, %0d undersize, %0d oversize, %0d out of heap",
                 result_count, ok_count, small_count, big_count, oom_count);
        $display("%0d allocations reused freed blocks; %0d long result stalls",
                 reuse_count, long_holds);
        if (fail_count == 0)
            $display("** segregated_free_list_allocator: PASSED **");
        else
            $display("** segregated_free_list_allocator: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/sfla_pkg.sv
rtl/sfla_ctrl.sv
rtl/sfla_dp.sv
rtl/segregated_free_list_allocator.sv
tb/sv/segregated_free_list_allocator_checker.sv
tb/sv/segregated_free_list_allocator_test.sv
